### rtl/stoc_pkg.sv
// Shared widths, types and register codes for the segment/triangle occlusion test.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package stoc_pkg;

    localparam int CW        = 32;               // coordinate width
    localparam int DW        = CW + 1;           // coordinate difference width
    localparam int PW        = 2 * DW;           // product of two differences
    localparam int AW        = PW + 1;           // twice a triangle area, unsigned
    localparam int TOL_W     = 16;
    localparam int TOL_FRAC  = 16;
    localparam int NORM_W    = 21;
    localparam int NORM_FRAC = 19;
    localparam int NW        = NORM_W + DW + 3;  // plane numerator and denominator
    localparam int RW        = NW + 1;           // divider remainder
    localparam int QW        = TOL_FRAC;         // quotient width

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] diff_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic [AW-1:0]        area_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        coord_t cx;
        coord_t cy;
    } vtx_t;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [NW-1:0] dvs;
        logic [QW-1:0] q;
        logic          cq;
        logic          same;
        coord_t        sx;
        coord_t        sy;
        diff_t         dx;
        diff_t         dy;
    } div_t;

    typedef enum logic [2:0] {
        REG_VERTEX_A = 3'd0,
        REG_VERTEX_B = 3'd1,
        REG_VERTEX_C = 3'd2,
        REG_NORMAL   = 3'd3,
        REG_OFFSET   = 3'd4,
        REG_TOL      = 3'd5
    } reg_idx_t;

endpackage

### rtl/stoc_area_test.sv
// Five-stage pipelined point-in-triangle test using barycentric area sums.
// Depends on stoc_pkg for widths and the vertex struct.
`timescale 1ns / 1ps

module stoc_area_test
    import stoc_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic             strict,
    input  vtx_t             vtx,
    input  logic [TOL_W-1:0] tol,
    input  area_t            thr,
    input  coord_t           px,
    input  coord_t           py,
    output logic             in_tri
);

    localparam int SUM_W = AW + 2;
    localparam int DIF_W = SUM_W + 2;
    localparam int CMP_W = DIF_W + TOL_FRAC;

    typedef struct packed {
        diff_t e1x;
        diff_t e2y;
        diff_t e2x;
        diff_t e1y;
    } edge_t;

    coord_t p0x [4];
    coord_t p0y [4];
    coord_t p1x [4];
    coord_t p1y [4];
    coord_t p2x [4];
    coord_t p2y [4];

    edge_t               e_reg   [4];
    prod_t               m1_reg  [4];
    prod_t               m2_reg  [4];
    area_t               ar_reg  [4];
    logic [SUM_W-1:0]    s_reg;
    area_t               a_reg;
    logic [AW+TOL_W-1:0] atol_reg;
    logic                fail_reg;
    logic                in_tri_reg;

    logic signed [AW:0]       t_next [4];
    logic signed [DIF_W-1:0]  dif;
    logic signed [CMP_W-1:0]  lhs;
    logic signed [CMP_W-1:0]  rhs;

    // Area 0 is the triangle itself; areas 1..3 replace one vertex by the point.
    always_comb
    begin
        p0x[0] = vtx.ax; p0y[0] = vtx.ay; p1x[0] = vtx.bx; p1y[0] = vtx.by;
        p2x[0] = vtx.cx; p2y[0] = vtx.cy;
        p0x[1] = px;     p0y[1] = py;     p1x[1] = vtx.bx; p1y[1] = vtx.by;
        p2x[1] = vtx.cx; p2y[1] = vtx.cy;
        p0x[2] = vtx.ax; p0y[2] = vtx.ay; p1x[2] = px;     p1y[2] = py;
        p2x[2] = vtx.cx; p2y[2] = vtx.cy;
        p0x[3] = vtx.ax; p0y[3] = vtx.ay; p1x[3] = vtx.bx; p1y[3] = vtx.by;
        p2x[3] = px;     p2y[3] = py;
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            t_next[k] = (AW+1)'(m1_reg[k]) - (AW+1)'(m2_reg[k]);
        end
        dif = DIF_W'($signed({2'b00, s_reg})) - DIF_W'($signed({1'b0, a_reg}));
        lhs = CMP_W'(dif) <<< TOL_FRAC;
        rhs = CMP_W'($signed({1'b0, atol_reg}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                e_reg[k].e1x <= diff_t'(p1x[k]) - diff_t'(p0x[k]);
                e_reg[k].e2y <= diff_t'(p2y[k]) - diff_t'(p0y[k]);
                e_reg[k].e2x <= diff_t'(p2x[k]) - diff_t'(p0x[k]);
                e_reg[k].e1y <= diff_t'(p1y[k]) - diff_t'(p0y[k]);
                m1_reg[k]    <= prod_t'(e_reg[k].e1x) * prod_t'(e_reg[k].e2y);
                m2_reg[k]    <= prod_t'(e_reg[k].e2x) * prod_t'(e_reg[k].e1y);
                ar_reg[k]    <= t_next[k][AW] ? AW'(-t_next[k]) : AW'(t_next[k]);
            end
            s_reg    <= SUM_W'(ar_reg[1]) + SUM_W'(ar_reg[2]) + SUM_W'(ar_reg[3]);
            a_reg    <= ar_reg[0];
            atol_reg <= (AW+TOL_W)'(ar_reg[0]) * (AW+TOL_W)'(tol);
            fail_reg <= strict && ((ar_reg[1] <= thr) || (ar_reg[2] <= thr) ||
                                   (ar_reg[3] <= thr));
            in_tri_reg <= !fail_reg && (lhs <= rhs);
        end
    end

    assign in_tri = in_tri_reg;

endmodule

### rtl/segment_triangle_occlusion_test.sv
// Segment against occluder triangle, fully pipelined: one request per cycle while the output
// is not stalled. All stages, including the 16-stage restoring divider and the two 5-stage
// area pipelines, advance together on one shared enable.
// Reset (rst_n low, asynchronous) clears all valid bits and the configuration registers; tolerance -> 1.
`timescale 1ns / 1ps

module segment_triangle_occlusion_test
    import stoc_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z (32 bits each, lowest first)
    input  logic [191:0] s_tdata,
    // same_triangle
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // crosses [0], cross_fraction [16:1], hidden [17], zero padding [23:18]
    output logic [23:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    // Threshold shifts that bring the Q0.16 tolerance into area and
    // denominator units.
    localparam int AREA_SH  = 2 * COORD_FRAC_BITS + 1 - TOL_FRAC;
    localparam int DEN_SH   = COORD_FRAC_BITS + NORM_FRAC - TOL_FRAC;

    localparam int LAT      = 28;
    localparam int NDIV     = QW;
    localparam int TAIL_LEN = 5;
    localparam int HID_LEN  = 20;       // positions 8 through 27
    localparam int LHS_W    = 2 * CW + NORM_W + 1 - CW + CW - CW + TOL_FRAC;  // 70
    localparam int RHS_W    = NW + 2 + TOL_FRAC;                               // 75
    localparam int MP_W     = NORM_W + DW;                                     // 54
    localparam int XP_W     = DW + QW + 1;                                     // 50

    localparam int OUT_CROSS = 0;
    localparam int OUT_HID   = 17;

    // ------------------------------------------------------------------
    // Configuration registers. Writes must happen only while the pipe is
    // idle; the block does not enforce it. Every stage reads them directly.
    // ------------------------------------------------------------------
    logic [63:0]      va_reg;
    logic [63:0]      vb_reg;
    logic [63:0]      vc_reg;
    logic [62:0]      n_reg;
    logic [31:0]      o_reg;
    logic [TOL_W-1:0] tol_reg;
    reg_idx_t         cfg_idx;
    logic             cfg_wr;

    assign cfg_idx = reg_idx_t'(paddr[5:3]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg  <= '0;
            vb_reg  <= '0;
            vc_reg  <= '0;
            n_reg   <= '0;
            o_reg   <= '0;
            tol_reg <= TOL_W'(1);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_VERTEX_A: va_reg  <= pwdata;
                REG_VERTEX_B: vb_reg  <= pwdata;
                REG_VERTEX_C: vc_reg  <= pwdata;
                REG_NORMAL:   n_reg   <= pwdata[62:0];
                REG_OFFSET:   o_reg   <= pwdata[31:0];
                REG_TOL:      tol_reg <= pwdata[TOL_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_VERTEX_A: prdata = va_reg;
            REG_VERTEX_B: prdata = vb_reg;
            REG_VERTEX_C: prdata = vc_reg;
            REG_NORMAL:   prdata = {1'b0, n_reg};
            REG_OFFSET:   prdata = {32'd0, o_reg};
            REG_TOL:      prdata = {{(64-TOL_W){1'b0}}, tol_reg};
            default:      prdata = '0;
        endcase
    end

    // Decoded fields of the configuration.
    vtx_t                      vtx;
    logic signed [NORM_W-1:0]  nx;
    logic signed [NORM_W-1:0]  ny;
    logic signed [NORM_W-1:0]  nz;
    logic [NORM_W-1:0]         nz_abs;
    logic signed [NW-1:0]      o19;
    logic [NW-1:0]             den_thr;
    area_t                     area_thr;

    assign vtx.ax   = va_reg[63:32];
    assign vtx.ay   = va_reg[31:0];
    assign vtx.bx   = vb_reg[63:32];
    assign vtx.by   = vb_reg[31:0];
    assign vtx.cx   = vc_reg[63:32];
    assign vtx.cy   = vc_reg[31:0];
    assign nx       = n_reg[62:42];
    assign ny       = n_reg[41:21];
    assign nz       = n_reg[20:0];
    assign nz_abs   = nz[NORM_W-1] ? (~n_reg[20:0] + NORM_W'(1)) : n_reg[20:0];
    assign o19      = {{(NW-CW-NORM_FRAC){o_reg[31]}}, o_reg, {NORM_FRAC{1'b0}}};
    assign den_thr  = NW'(tol_reg) << DEN_SH;
    assign area_thr = AW'(tol_reg) << AREA_SH;

    // ------------------------------------------------------------------
    // Pipeline control. All stages move together; the last stage is the
    // output register, so a request enters whenever the result in front of
    // it is either absent or being taken.
    // ------------------------------------------------------------------
    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: unpack, direction and midpoint.
    // ------------------------------------------------------------------
    typedef struct packed {
        coord_t sx; coord_t sy; coord_t sz;
        diff_t  dx; diff_t  dy; diff_t  dz;
        coord_t mx; coord_t my; coord_t mz;
        logic   same;
    } s1_t;

    typedef struct packed {
        logic signed [MP_W-1:0] pnx; logic signed [MP_W-1:0] pny;
        logic signed [MP_W-1:0] pnz;
        logic signed [MP_W-1:0] pdx; logic signed [MP_W-1:0] pdy;
        logic signed [MP_W-1:0] pdz;
        logic signed [MP_W-1:0] pmx; logic signed [MP_W-1:0] pmy;
        logic signed [MP_W-1:0] pmz;
        coord_t mx; coord_t my;
        logic   mz_neg;
        coord_t sx; coord_t sy;
        diff_t  dx; diff_t  dy;
        logic   same;
    } s2_t;

    typedef struct packed {
        logic signed [NW-1:0]    num;
        logic signed [NW-1:0]    den;
        logic signed [NW-1:0]    pn;
        logic signed [LHS_W-1:0] lhs;
        logic   mz_neg;
        coord_t sx; coord_t sy;
        diff_t  dx; diff_t  dy;
        logic   same;
    } s3_t;

    typedef struct packed {
        logic [NW-1:0]           anum;
        logic [NW-1:0]           aden;
        logic                    cq;
        logic signed [NW:0]      pnn;
        logic [NW-1:0]           pabs;
        logic signed [LHS_W-1:0] lhs;
        logic   mz_neg;
        coord_t sx; coord_t sy;
        diff_t  dx; diff_t  dy;
        logic   same;
    } s4_t;

    typedef struct packed {
        logic [NW+TOL_W-1:0]     tolp;
        logic signed [NW:0]      pnn;
        logic signed [LHS_W-1:0] lhs;
        logic                    mz_neg;
    } h5_t;

    typedef struct packed {
        logic signed [RHS_W-1:0] rhs;
        logic signed [LHS_W-1:0] lhs;
        logic                    mz_neg;
    } h6_t;

    typedef struct packed {
        logic signed [XP_W-1:0] prx;
        logic signed [XP_W-1:0] pry;
        coord_t sx; coord_t sy;
        logic [QW-1:0] q;
        logic cq;
        logic same;
    } x1_t;

    typedef struct packed {
        coord_t px; coord_t py;
        logic [QW-1:0] q;
        logic cq;
        logic same;
    } x2_t;

    typedef struct packed {
        logic [QW-1:0] q;
        logic cq;
        logic same;
    } tail_t;

    s1_t              s1_reg;
    s1_t              s1_next;
    s2_t              s2_reg;
    s3_t              s3_reg;
    s4_t              s4_reg;
    s4_t              s4_next;
    h5_t              h5_reg;
    h6_t              h6_reg;
    logic             below_reg;
    div_t             div_reg [NDIV];
    div_t             div_next;
    x1_t              x1_reg;
    x2_t              x2_reg;
    tail_t            tail_reg [TAIL_LEN];
    logic [HID_LEN-1:0] hid_sr_reg;
    logic [23:0]      out_data_reg;

    logic             mid_in_tri;
    logic             cross_in_tri;
    logic             hid7;

    // One restoring division step: shift in a zero, subtract if it fits.
    function automatic div_t div_step(div_t d);
        div_t          r;
        logic [RW-1:0] r2;
        r  = d;
        r2 = {d.rem[RW-2:0], 1'b0};
        if (r2 >= {1'b0, d.dvs})
        begin
            r.rem = r2 - {1'b0, d.dvs};
            r.q   = {d.q[QW-2:0], 1'b1};
        end
        else
        begin
            r.rem = r2;
            r.q   = {d.q[QW-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        logic signed [DW-1:0] sum_x;
        logic signed [DW-1:0] sum_y;
        logic signed [DW-1:0] sum_z;
        s1_next.sx   = s_tdata[31:0];
        s1_next.sy   = s_tdata[63:32];
        s1_next.sz   = s_tdata[95:64];
        s1_next.dx   = diff_t'($signed(s_tdata[127:96]))  - diff_t'($signed(s_tdata[31:0]));
        s1_next.dy   = diff_t'($signed(s_tdata[159:128])) - diff_t'($signed(s_tdata[63:32]));
        s1_next.dz   = diff_t'($signed(s_tdata[191:160])) - diff_t'($signed(s_tdata[95:64]));
        sum_x        = diff_t'($signed(s_tdata[127:96]))  + diff_t'($signed(s_tdata[31:0]));
        sum_y        = diff_t'($signed(s_tdata[159:128])) + diff_t'($signed(s_tdata[63:32]));
        sum_z        = diff_t'($signed(s_tdata[191:160])) + diff_t'($signed(s_tdata[95:64]));
        // An arithmetic shift by one is the floor of half the sum.
        s1_next.mx   = sum_x[DW-1:1];
        s1_next.my   = sum_y[DW-1:1];
        s1_next.mz   = sum_z[DW-1:1];
        s1_next.same = s_tuser[0];
    end

    // Stage 4: magnitudes and the crossing qualification. The divider then
    // only has to produce the fraction bits of |num| / |den|.
    always_comb
    begin
        s4_next.anum   = s3_reg.num[NW-1] ? NW'(-s3_reg.num) : NW'(s3_reg.num);
        s4_next.aden   = s3_reg.den[NW-1] ? NW'(-s3_reg.den) : NW'(s3_reg.den);
        s4_next.cq     = (s4_next.aden > den_thr) && (s3_reg.num != '0) &&
                         (s3_reg.num[NW-1] == s3_reg.den[NW-1]) &&
                         (s4_next.anum < s4_next.aden);
        s4_next.pnn    = nz[NORM_W-1] ? -(NW+1)'(s3_reg.pn) : (NW+1)'(s3_reg.pn);
        s4_next.pabs   = s3_reg.pn[NW-1] ? NW'(-s3_reg.pn) : NW'(s3_reg.pn);
        s4_next.lhs    = s3_reg.lhs;
        s4_next.mz_neg = s3_reg.mz_neg;
        s4_next.sx     = s3_reg.sx;
        s4_next.sy     = s3_reg.sy;
        s4_next.dx     = s3_reg.dx;
        s4_next.dy     = s3_reg.dy;
        s4_next.same   = s3_reg.same;
    end

    always_comb
    begin
        div_next.rem  = {1'b0, s4_reg.anum};
        div_next.dvs  = s4_reg.aden;
        div_next.q    = '0;
        div_next.cq   = s4_reg.cq;
        div_next.same = s4_reg.same;
        div_next.sx   = s4_reg.sx;
        div_next.sy   = s4_reg.sy;
        div_next.dx   = s4_reg.dx;
        div_next.dy   = s4_reg.dy;
    end

    // Midpoint is hidden when strictly inside and strictly below the plane, unless the segment is the occluder's own.
    assign hid7 = mid_in_tri && below_reg && !div_reg[2].same;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;

            // Stage 2: every product with the normal.
            s2_reg.pnx    <= MP_W'(nx) * MP_W'(s1_reg.sx);
            s2_reg.pny    <= MP_W'(ny) * MP_W'(s1_reg.sy);
            s2_reg.pnz    <= MP_W'(nz) * MP_W'(s1_reg.sz);
            s2_reg.pdx    <= MP_W'(nx) * MP_W'(s1_reg.dx);
            s2_reg.pdy    <= MP_W'(ny) * MP_W'(s1_reg.dy);
            s2_reg.pdz    <= MP_W'(nz) * MP_W'(s1_reg.dz);
            s2_reg.pmx    <= MP_W'(nx) * MP_W'(s1_reg.mx);
            s2_reg.pmy    <= MP_W'(ny) * MP_W'(s1_reg.my);
            s2_reg.pmz    <= MP_W'(s1_reg.mz) * MP_W'($signed({1'b0, nz_abs}));
            s2_reg.mx     <= s1_reg.mx;
            s2_reg.my     <= s1_reg.my;
            s2_reg.mz_neg <= s1_reg.mz[CW-1];
            s2_reg.sx     <= s1_reg.sx;
            s2_reg.sy     <= s1_reg.sy;
            s2_reg.dx     <= s1_reg.dx;
            s2_reg.dy     <= s1_reg.dy;
            s2_reg.same   <= s1_reg.same;

            // Stage 3: plane numerator, denominator and depth numerator.
            s3_reg.num    <= o19 - (NW'(s2_reg.pnx) + NW'(s2_reg.pny) + NW'(s2_reg.pnz));
            s3_reg.den    <= NW'(s2_reg.pdx) + NW'(s2_reg.pdy) + NW'(s2_reg.pdz);
            s3_reg.pn     <= o19 - NW'(s2_reg.pmx) - NW'(s2_reg.pmy);
            s3_reg.lhs    <= LHS_W'(s2_reg.pmz) <<< TOL_FRAC;
            s3_reg.mz_neg <= s2_reg.mz_neg;
            s3_reg.sx     <= s2_reg.sx;
            s3_reg.sy     <= s2_reg.sy;
            s3_reg.dx     <= s2_reg.dx;
            s3_reg.dy     <= s2_reg.dy;
            s3_reg.same   <= s2_reg.same;

            s4_reg <= s4_next;

            // Depth lane: relative tolerance, then the cross-multiplied compare.
            h5_reg.tolp   <= (NW+TOL_W)'(s4_reg.pabs) * (NW+TOL_W)'(tol_reg);
            h5_reg.pnn    <= s4_reg.pnn;
            h5_reg.lhs    <= s4_reg.lhs;
            h5_reg.mz_neg <= s4_reg.mz_neg;

            h6_reg.rhs    <= RHS_W'($signed({h5_reg.pnn, {TOL_FRAC{1'b0}}})) -
                             RHS_W'($signed({2'b00, h5_reg.tolp}));
            h6_reg.lhs    <= h5_reg.lhs;
            h6_reg.mz_neg <= h5_reg.mz_neg;

            below_reg <= (nz == '0) ? h6_reg.mz_neg : (RHS_W'(h6_reg.lhs) < h6_reg.rhs);

            // Divider: one quotient bit per stage.
            div_reg[0] <= div_step(div_next);
            for (int k = 1; k < NDIV; k++)
            begin
                div_reg[k] <= div_step(div_reg[k-1]);
            end

            // Crossing point: scale the direction by the fraction.
            x1_reg.prx  <= XP_W'(div_reg[NDIV-1].dx) *
                           XP_W'($signed({1'b0, div_reg[NDIV-1].q}));
            x1_reg.pry  <= XP_W'(div_reg[NDIV-1].dy) *
                           XP_W'($signed({1'b0, div_reg[NDIV-1].q}));
            x1_reg.sx   <= div_reg[NDIV-1].sx;
            x1_reg.sy   <= div_reg[NDIV-1].sy;
            x1_reg.q    <= div_reg[NDIV-1].q;
            x1_reg.cq   <= div_reg[NDIV-1].cq;
            x1_reg.same <= div_reg[NDIV-1].same;

            // The point stays between the ends, so it fits a coordinate.
            x2_reg.px   <= CW'(DW'(x1_reg.sx) + DW'(x1_reg.prx >>> TOL_FRAC));
            x2_reg.py   <= CW'(DW'(x1_reg.sy) + DW'(x1_reg.pry >>> TOL_FRAC));
            x2_reg.q    <= x1_reg.q;
            x2_reg.cq   <= x1_reg.cq;
            x2_reg.same <= x1_reg.same;

            tail_reg[0].q    <= x2_reg.q;
            tail_reg[0].cq   <= x2_reg.cq;
            tail_reg[0].same <= x2_reg.same;
            for (int k = 1; k < TAIL_LEN; k++)
            begin
                tail_reg[k] <= tail_reg[k-1];
            end

            hid_sr_reg <= {hid_sr_reg[HID_LEN-2:0], hid7};

            // Output register.
            out_data_reg[OUT_CROSS] <= tail_reg[TAIL_LEN-1].cq && cross_in_tri &&
                                       !tail_reg[TAIL_LEN-1].same;
            out_data_reg[16:1]      <= (tail_reg[TAIL_LEN-1].cq && cross_in_tri &&
                                        !tail_reg[TAIL_LEN-1].same) ?
                                       tail_reg[TAIL_LEN-1].q : '0;
            out_data_reg[OUT_HID]   <= hid_sr_reg[HID_LEN-1];
            out_data_reg[23:18]     <= '0;
        end
    end

    assign m_tdata = out_data_reg;

    // Midpoint: strict form, edges and near-edge points count as outside.
    stoc_area_test u_mid_area
    (
        .clk    (clk),
        .en     (en),
        .strict (1'b1),
        .vtx    (vtx),
        .tol    (tol_reg),
        .thr    (area_thr),
        .px     (s2_reg.mx),
        .py     (s2_reg.my),
        .in_tri (mid_in_tri)
    );

    // Crossing point: edges count as inside.
    stoc_area_test u_cross_area
    (
        .clk    (clk),
        .en     (en),
        .strict (1'b0),
        .vtx    (vtx),
        .tol    (tol_reg),
        .thr    (area_thr),
        .px     (x2_reg.px),
        .py     (x2_reg.py),
        .in_tri (cross_in_tri)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_frac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[OUT_CROSS]) |-> (m_tdata[16:1] == '0))
        else $error("cross_fraction set without a crossing");

    a_same_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[LAT-2] && tail_reg[TAIL_LEN-1].same) |=>
        (m_tvalid && !m_tdata[OUT_CROSS] && !m_tdata[OUT_HID]))
        else $error("flags raised for a segment of the occluder itself");

    a_unqualified: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[LAT-2] && !tail_reg[TAIL_LEN-1].cq) |=> !m_tdata[OUT_CROSS])
        else $error("crossing reported without a qualified plane hit");

endmodule

### dv/segment_triangle_occlusion_test_check.sv
// Result checker for the segment/triangle occlusion test: tracks register writes on
// the APB port, computes each expected result from the accepted requests, compares.
// Depends on stoc_pkg for register codes.
`timescale 1ns / 1ps

module segment_triangle_occlusion_test_check
    import stoc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [191:0] s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [23:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    input  logic         pready,
    output int           errors,
    output int           outstanding
);

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic        hidden;
        logic [15:0] fraction;
        logic        crosses;
    } occl_t;

    logic [63:0] va, vb, vc;
    logic [62:0] nrm;
    logic [31:0] offs;
    logic [15:0] tol;
    occl_t       occl_q[$];

    assign outstanding = occl_q.size();

    function automatic wide_t area2(longint ax, longint ay, longint bx, longint by,
                                    longint cx, longint cy);
        wide_t v;
        v = wide_t'(bx - ax) * wide_t'(cy - ay) - wide_t'(cx - ax) * wide_t'(by - ay);
        return v < 0 ? -v : v;
    endfunction

    // Point in triangle by area sums; the strict form also rejects points near an edge.
    function automatic logic in_triangle(longint px, longint py, logic strict);
        longint ax, ay, bx, by, cx, cy;
        wide_t  a, a1, a2, a3, thr;
        ax = longint'($signed(va[63:32])); ay = longint'($signed(va[31:0]));
        bx = longint'($signed(vb[63:32])); by = longint'($signed(vb[31:0]));
        cx = longint'($signed(vc[63:32])); cy = longint'($signed(vc[31:0]));
        a  = area2(ax, ay, bx, by, cx, cy);
        a1 = area2(px, py, bx, by, cx, cy);
        a2 = area2(ax, ay, px, py, cx, cy);
        a3 = area2(ax, ay, bx, by, px, py);
        thr = wide_t'(tol) <<< 17;
        if (strict && (a1 <= thr || a2 <= thr || a3 <= thr))
            return 1'b0;
        return !(a * wide_t'(tol) < ((a1 + a2 + a3 - a) <<< 16));
    endfunction

    function automatic occl_t occlusion(logic [191:0] d, logic same);
        occl_t  r;
        longint sx, sy, sz, ex, ey, ez, dx, dy, dz, nx, ny, nz, o19;
        longint num, den, rem, dv, mx, my, mz, pn, anz;
        logic [15:0] q;
        logic   below;
        wide_t  lhs, rhs;
        r = '0;
        sx = longint'($signed(d[31:0]));    sy = longint'($signed(d[63:32]));
        sz = longint'($signed(d[95:64]));   ex = longint'($signed(d[127:96]));
        ey = longint'($signed(d[159:128])); ez = longint'($signed(d[191:160]));
        nx = longint'($signed(nrm[62:42])); ny = longint'($signed(nrm[41:21]));
        nz = longint'($signed(nrm[20:0]));
        o19 = longint'($signed(offs)) * (64'sd1 <<< 19);
        if (same)
            return r;
        dx = ex - sx; dy = ey - sy; dz = ez - sz;
        num = o19 - (nx * sx + ny * sy + nz * sz);
        den = nx * dx + ny * dy + nz * dz;
        rem = num < 0 ? -num : num;
        dv  = den < 0 ? -den : den;
        if (dv > (longint'(tol) <<< 19) && num != 0 && ((num < 0) == (den < 0)) && rem < dv)
        begin
            q = '0;
            for (int i = 0; i < 16; i++)
            begin
                rem = rem <<< 1;
                q = q << 1;
                if (rem >= dv)
                begin
                    rem -= dv;
                    q[0] = 1'b1;
                end
            end
            if (in_triangle(sx + ((dx * longint'(q)) >>> 16),
                            sy + ((dy * longint'(q)) >>> 16), 1'b0))
            begin
                r.crosses  = 1'b1;
                r.fraction = q;
            end
        end
        mx = (sx + ex) >>> 1; my = (sy + ey) >>> 1; mz = (sz + ez) >>> 1;
        if (in_triangle(mx, my, 1'b1))
        begin
            if (nz == 0)
                below = mz < 0;
            else
            begin
                pn = o19 - nx * mx - ny * my;
                if (nz < 0)
                    pn = -pn;
                anz = nz < 0 ? -nz : nz;
                lhs = (wide_t'(mz) * wide_t'(anz)) <<< 16;
                rhs = (wide_t'(pn) <<< 16) - wide_t'(tol) * wide_t'(pn < 0 ? -pn : pn);
                below = lhs < rhs;
            end
            r.hidden = below;
        end
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        occl_t got, want;
        if (!rst_n)
        begin
            va <= '0; vb <= '0; vc <= '0; nrm <= '0; offs <= '0; tol <= 16'd1;
            occl_q.delete();
            errors = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2:0] == 3'd0)
            begin
                case (paddr[5:3])
                    REG_VERTEX_A: va   <= pwdata;
                    REG_VERTEX_B: vb   <= pwdata;
                    REG_VERTEX_C: vc   <= pwdata;
                    REG_NORMAL:   nrm  <= pwdata[62:0];
                    REG_OFFSET:   offs <= pwdata[31:0];
                    REG_TOL:      tol  <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = occl_t'(m_tdata[17:0]);
                if (occl_q.size() == 0)
                    report("unexpected result", m_tdata, 0);
                else
                begin
                    want = occl_q.pop_front();
                    if (got.crosses != want.crosses)
                        report("crosses", got.crosses, want.crosses);
                    if (got.fraction != want.fraction)
                        report("cross_fraction", got.fraction, want.fraction);
                    if (got.hidden != want.hidden)
                        report("hidden", got.hidden, want.hidden);
                end
            end
            if (s_tvalid && s_tready)
                occl_q = {occl_q, occlusion(s_tdata, s_tuser[0])};
        end
    end

endmodule

### dv/segment_triangle_occlusion_test_test.sv
// Testbench top for the segment/triangle occlusion test: clock, reset, APB register
// setup, request stimulus and the verdict. Depends on stoc_pkg, the block and the checker.
`timescale 1ns / 1ps

module segment_triangle_occlusion_test_test
    import stoc_pkg::*;
();

    localparam int LATENCY   = 40;     // pipeline depth is 28; some margin on top
    localparam int STALL_MAX = 20000;  // cycles without any handshake before giving up

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;      // start_x, start_y, start_z, end_x, end_y, end_z
    logic [0:0]   s_tuser = '0;      // same_triangle
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;           // crosses, cross_fraction, hidden, padding
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [5:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;
    int           errors;
    int           outstanding;
    int           snd_idle = 37;
    int           rcv_idle = 58;
    int           quiet = 0;

    segment_triangle_occlusion_test i_dut (.*);
    segment_triangle_occlusion_test_check i_check (.*);

    always #5 clk = ~clk;

    // The receiver decides at every falling edge whether it takes a result.
    always @(negedge clk)
        m_tready = ($urandom_range(99) >= rcv_idle);

    // Watchdog: a stretch with no handshake on either stream means the block hung.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_MAX)
        begin
            $display("FAIL segment_triangle_occlusion_test");
            $finish;
        end
    end

    // Pixels to Q16.16.
    function automatic logic [31:0] px(int p);
        return 32'(p * 65536);
    endfunction

    function automatic logic [63:0] vertex(int x, int y);
        return {px(x), px(y)};
    endfunction

    function automatic logic [31:0] near_coord(int span);
        return 32'($urandom_range(0, 2 * span * 65536) - span * 65536);
    endfunction

    // A register write takes a setup and an access phase.
    task automatic reg_write(reg_idx_t idx, logic [63:0] value);
        @(negedge clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = 6'(idx) << 3; pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // Registers change only once the pipeline has drained.
    task automatic drain();
        while (outstanding != 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic setup(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                         logic [62:0] n, logic [31:0] o, logic [15:0] t);
        drain();
        reg_write(REG_VERTEX_A, a);
        reg_write(REG_VERTEX_B, b);
        reg_write(REG_VERTEX_C, c);
        reg_write(REG_NORMAL, {1'b0, n});
        reg_write(REG_OFFSET, {32'b0, o});
        reg_write(REG_TOL, {48'b0, t});
    endtask

    // Random occluder near the origin; the offset puts vertex A on the plane.
    task automatic random_setup(logic [15:0] t);
        int          ax, ay, az, bx, by, cx, cy;
        longint      nx, ny, nz;
        logic [31:0] o;
        ax = $urandom_range(300) - 150; ay = $urandom_range(300) - 150;
        bx = $urandom_range(300) - 150; by = $urandom_range(300) - 150;
        cx = $urandom_range(300) - 150; cy = $urandom_range(300) - 150;
        az = $urandom_range(100) - 50;
        nx = longint'($urandom_range(1 << 19)) - (1 << 18);
        ny = longint'($urandom_range(1 << 19)) - (1 << 18);
        nz = longint'($urandom_range(1 << 19, 1 << 18));
        if ($urandom_range(1))
            nz = -nz;
        o = 32'((nx * longint'($signed(px(ax))) + ny * longint'($signed(px(ay)))
                 + nz * longint'($signed(px(az)))) >>> 19);
        setup(vertex(ax, ay), vertex(bx, by), vertex(cx, cy),
              {21'(nx), 21'(ny), 21'(nz)}, o, t);
    endtask

    // Presents one request and holds it until the block takes it.
    task automatic send(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                        logic [31:0] ex, logic [31:0] ey, logic [31:0] ez, logic same);
        while ($urandom_range(99) < snd_idle)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {ez, ey, ex, sz, sy, sx};
        s_tuser = same;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Mostly segments around the occluder with random content, some full-range noise.
    task automatic random_requests(int count);
        logic [31:0] c[6];
        for (int i = 0; i < count; i++)
        begin
            for (int k = 0; k < 6; k++)
                c[k] = ($urandom_range(9) == 0) ? $urandom() : near_coord(200);
            send(c[0], c[1], c[2], c[3], c[4], c[5], $urandom_range(19) == 0);
            // One pause where the sender waits for every pending result.
            if (i == count / 2 && snd_idle == 0)
            begin
                s_tvalid = 1'b0;
                while (outstanding != 0)
                    @(negedge clk);
            end
        end
        s_tvalid = 1'b0;
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed: right triangle in z = 0, unit normal along z.
        setup(vertex(0, 0), vertex(100, 0), vertex(0, 100),
              {21'd0, 21'd0, 21'h80000}, 32'd0, 16'd1);
        send(px(10), px(10), px(-5), px(10), px(10), px(5), 1'b0);     // pierces at half way
        send(px(10), px(10), px(-10), px(20), px(20), px(-2), 1'b0);   // wholly below: hidden
        send(px(10), px(10), px(-10), px(20), px(20), px(-2), 1'b1);   // same triangle
        send(px(0), px(50), px(-4), px(0), px(50), px(4), 1'b0);       // crossing on an edge
        send(px(0), px(50), px(-4), px(0), px(50), px(-2), 1'b0);      // midpoint on an edge
        send(px(200), px(200), px(-5), px(200), px(200), px(5), 1'b0); // outside in XY
        send(px(10), px(10), px(0), px(10), px(10), px(8), 1'b0);      // starts on the plane
        send(px(10), px(10), px(-8), px(10), px(10), px(0), 1'b0);     // ends on the plane
        send(px(10), px(10), px(3), px(40), px(10), px(3), 1'b0);      // parallel above
        send(px(10), px(10), -32'sd1, px(10), px(10), 32'sd1, 1'b0);   // tiny span
        send(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
             32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
        send(32'h80000000, 32'h80000000, 32'h80000000,
             32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);
        send(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 1'b0);
        send(0, 0, 0, 0, 0, 0, 1'b0);
        s_tvalid = 1'b0;

        // Directed: degenerate triangle and a normal with no z part.
        setup(vertex(5, 5), vertex(5, 5), vertex(5, 5),
              {21'h80000, 21'd0, 21'd0}, px(5), 16'd0);
        send(px(0), px(5), px(-1), px(10), px(5), px(-3), 1'b0);
        send(px(5), px(5), px(-1), px(5), px(5), px(-3), 1'b0);
        send(px(4), px(4), px(1), px(6), px(6), px(1), 1'b0);
        s_tvalid = 1'b0;

        // Random phases, each with its own occluder and tolerance.
        random_setup(16'($urandom_range(1, 2000)));
        random_requests(250);
        random_setup(16'd0);
        random_requests(200);

        snd_idle = 58;
        rcv_idle = 37;
        random_setup(16'hffff);
        random_requests(100);
        // Full-range register contents: every register bit is random.
        setup($urandom() | 64'($urandom()) << 32, {$urandom(), $urandom()},
              {$urandom(), $urandom()}, {31'($urandom()), $urandom()}, $urandom(),
              16'($urandom()));
        random_requests(50);

        snd_idle = 0;
        rcv_idle = 0;
        random_setup(16'($urandom()));
        random_requests(300);

        drain();
        if (errors == 0)
            $display("PASS segment_triangle_occlusion_test");
        else
            $display("FAIL segment_triangle_occlusion_test");
        $finish;
    end

endmodule
